### hw/rtl/urf_pkg.sv
// shared types, constants and helpers for the serial port ring buffer block
// no dependencies; imported by urf_ctrl and the top level (urf_ram does not use it)
package urf_pkg;

   // ring sizes and derived widths
   localparam int RX_DEPTH = 128;
   localparam int TX_DEPTH = 128;
   localparam int RX_PW    = $clog2(RX_DEPTH);
   localparam int TX_PW    = $clog2(TX_DEPTH);
   localparam int BYTE_W   = 8;
   localparam int LEVEL_W  = 7;
   localparam int FILL_W   = 9;

   // opcodes
   localparam logic [1:0] OP_LINE_RX    = 2'd0;
   localparam logic [1:0] OP_LINE_READY = 2'd1;
   localparam logic [1:0] OP_HOST_READ  = 2'd2;
   localparam logic [1:0] OP_HOST_WRITE = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_PARITY = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [BYTE_W-1:0] data_byte;
      logic              ninth_bit;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [BYTE_W-1:0]  read_data;
      logic               line_send;
      logic [BYTE_W-1:0]  line_data;
      logic               line_ninth_bit;
      logic [LEVEL_W-1:0] rx_level;
      logic [LEVEL_W-1:0] tx_level;
   } rsp_type;

   // memory commands from the pointer logic
   typedef struct packed {
      logic             wr_en;
      logic [RX_PW-1:0] wr_addr;
      logic             rd_en;
      logic [RX_PW-1:0] rd_addr;
   } rx_cmd_type;

   typedef struct packed {
      logic             wr_en;
      logic [TX_PW-1:0] wr_addr;
      logic             rd_en;
      logic [TX_PW-1:0] rd_addr;
   } tx_cmd_type;

   // item in flight while the memory read completes
   typedef struct packed {
      logic [1:0]         status;
      logic               rx_rd;
      logic               tx_rd;
      logic               bypass;
      logic [BYTE_W-1:0]  data_byte;
      logic [LEVEL_W-1:0] rx_level;
      logic [LEVEL_W-1:0] tx_level;
   } pend_type;

   // bytes waiting in a ring, masked to the level width
   function automatic logic [LEVEL_W-1:0] fill_level(input logic [FILL_W-1:0] head,
                                                     input logic [FILL_W-1:0] tail,
                                                     input logic [FILL_W-1:0] depth);
      logic [FILL_W-1:0] fill;
      if (head >= tail) fill = head - tail;
      else              fill = head + depth - tail;
      return fill[LEVEL_W-1:0];
   endfunction

endpackage

### hw/rtl/urf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module urf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read, read data holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/urf_ctrl.sv
// ring pointers for both rings, per-item decision and memory commands
// depends on urf_pkg
module urf_ctrl import urf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req,
   output rx_cmd_type rx_cmd,
   output tx_cmd_type tx_cmd,
   output pend_type   pend_in
);

   logic [RX_PW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TX_PW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [RX_PW-1:0] rx_head_nx, rx_tail_nx;
   logic [TX_PW-1:0] tx_head_nx, tx_tail_nx;
   logic             parity_odd;

   // wrapped increments
   always_comb begin
      rx_head_nx = (rx_head_ff == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_head_ff + 1'b1;
      rx_tail_nx = (rx_tail_ff == RX_PW'(RX_DEPTH - 1)) ? '0 : rx_tail_ff + 1'b1;
      tx_head_nx = (tx_head_ff == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_head_ff + 1'b1;
      tx_tail_nx = (tx_tail_ff == TX_PW'(TX_DEPTH - 1)) ? '0 : tx_tail_ff + 1'b1;
   end

   assign parity_odd = ^{req.ninth_bit, req.data_byte};

   // decide the item and drive the memories
   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      rx_cmd     = '{wr_en: 1'b0, wr_addr: rx_head_ff, rd_en: 1'b0, rd_addr: rx_tail_ff};
      tx_cmd     = '{wr_en: 1'b0, wr_addr: tx_head_ff, rd_en: 1'b0, rd_addr: tx_tail_ff};
      pend_in           = '0;
      pend_in.status    = ST_OK;
      pend_in.data_byte = req.data_byte;
      case (req.opcode)
         OP_LINE_RX: begin
            if (!parity_odd) begin
               pend_in.status = ST_PARITY;
            end else if (rx_head_nx == rx_tail_ff) begin
               pend_in.status = ST_FULL;
            end else begin
               rx_cmd.wr_en = accept;
               rx_head_in   = rx_head_nx;
            end
         end
         OP_LINE_READY: begin
            if (tx_tail_ff == tx_head_ff) begin
               pend_in.status = ST_EMPTY;
            end else begin
               tx_cmd.rd_en  = accept;
               pend_in.tx_rd = 1'b1;
               tx_tail_in    = tx_tail_nx;
            end
         end
         OP_HOST_READ: begin
            if (rx_tail_ff == rx_head_ff) begin
               pend_in.status = ST_EMPTY;
            end else begin
               rx_cmd.rd_en  = accept;
               pend_in.rx_rd = 1'b1;
               rx_tail_in    = rx_tail_nx;
            end
         end
         default: begin
            if (tx_head_nx == tx_tail_ff) begin
               pend_in.status = ST_FULL;
            end else begin
               tx_cmd.wr_en = accept;
               tx_head_in   = tx_head_nx;
               // empty ring: the byte goes straight to the line
               if (tx_head_ff == tx_tail_ff) begin
                  pend_in.bypass = 1'b1;
                  tx_tail_in     = tx_tail_nx;
               end
            end
         end
      endcase
      pend_in.rx_level = fill_level(FILL_W'(rx_head_in), FILL_W'(rx_tail_in),
                                    FILL_W'(RX_DEPTH));
      pend_in.tx_level = fill_level(FILL_W'(tx_head_in), FILL_W'(tx_tail_in),
                                    FILL_W'(TX_DEPTH));
   end

   // pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
      end else if (accept) begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
      end
   end

endmodule

### hw/rtl/uart_ring_fifos_odd_parity.sv
// top level of the serial port ring buffer block: rings, read stage, output register
// depends on urf_pkg, urf_ram and urf_ctrl
//
//   channel  handshake            payload    direction
//   req      req_valid/req_stall  req_data   in,  one event item
//   rsp      rsp_valid/rsp_stall  rsp_data   out, one result item per event
//
// one item per cycle when the result side keeps up; an accepted item is
// registered in the read stage, then its result in the output register.
// the ring stores are not cleared; reset zeroes the four pointers and the two valid bits only.
// a stalled result holds in the output register while one more item is
// taken into the read stage, then the input stalls.
module uart_ring_fifos_odd_parity import urf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   rx_cmd_type        rx_cmd;
   tx_cmd_type        tx_cmd;
   pend_type          pend_in, pend_ff;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [BYTE_W-1:0] rx_rd_data, tx_rd_data, line_byte;
   logic              accept, out_free, advance, send;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = pend_valid_ff && out_free;
   assign req_stall = pend_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   urf_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .rx_cmd  (rx_cmd),
      .tx_cmd  (tx_cmd),
      .pend_in (pend_in)
   );

   urf_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_cmd.wr_en),
      .wr_addr (rx_cmd.wr_addr),
      .wr_data (req_data.data_byte),
      .rd_en   (rx_cmd.rd_en),
      .rd_addr (rx_cmd.rd_addr),
      .rd_data (rx_rd_data)
   );

   urf_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_cmd.wr_en),
      .wr_addr (tx_cmd.wr_addr),
      .wr_data (req_data.data_byte),
      .rd_en   (tx_cmd.rd_en),
      .rd_addr (tx_cmd.rd_addr),
      .rd_data (tx_rd_data)
   );

   // build the result from the read stage and the ram outputs
   always_comb begin
      send      = pend_ff.bypass || pend_ff.tx_rd;
      line_byte = pend_ff.bypass ? pend_ff.data_byte :
                  (pend_ff.tx_rd ? tx_rd_data : '0);
      rsp_in.status         = pend_ff.status;
      rsp_in.read_data      = pend_ff.rx_rd ? rx_rd_data : '0;
      rsp_in.line_send      = send;
      rsp_in.line_data      = line_byte;
      rsp_in.line_ninth_bit = send && !(^line_byte);
      rsp_in.rx_level       = pend_ff.rx_level;
      rsp_in.tx_level       = pend_ff.tx_level;
   end

   // valid bits of the read stage and output register
   always_comb begin
      pend_valid_in = accept || (pend_valid_ff && !advance);
      rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept)  pend_ff <= pend_in;
      if (advance) rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // an accepted item always reaches the read stage
   a_accept_to_pend: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_valid_ff)
      else $error("accepted item missing from read stage");

   // a line send only comes with an ok status
   a_send_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.line_send) |-> (rsp_data.status == ST_OK))
      else $error("line send with error status");

   // no line send means zero line fields
   a_idle_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.line_send) |->
         (rsp_data.line_data == '0 && !rsp_data.line_ninth_bit))
      else $error("line fields set without a send");

   // the read stage never holds two items: a stalled output blocks the input
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("item accepted while read stage is blocked");
`endif

endmodule
